[sv/firfc_pkg.sv]
// ----------------------------------------------------------------------------
// firfc_pkg
// shared constants, types and coefficient helpers for the fir convolution block
// ----------------------------------------------------------------------------
package firfc_pkg;

    localparam int TAPS_DEF     = 8;
    localparam int SAMPLE_W_DEF = 16;
    localparam int VALUE_W      = 35;
    localparam int COEF_W       = 16;
    localparam int REG_TAPS     = 8;
    localparam int TAP_COUNT_W  = 4;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int GROUP        = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT = 2'd0,
        CFG_COEF_LOW  = 2'd1,
        CFG_COEF_HIGH = 2'd2,
        CFG_REVERSE   = 2'd3
    } t_cfg_idx;

    // control that travels with one window through the back end
    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // tap k of the two packed coefficient registers, zero past the register taps
    function automatic logic signed [COEF_W-1:0] tap_of(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input int               k
    );
        logic [2*CFG_W-1:0] all_taps;
        logic [2:0]         k3;
        all_taps = {hi, lo};
        k3       = 3'(k);
        if (k < 0 || k >= REG_TAPS) begin
            return '0;
        end
        return $signed(all_taps[COEF_W*k3 +: COEF_W]);
    endfunction

endpackage

[sv/firfc_smp_if.sv]
// ----------------------------------------------------------------------------
// firfc_smp_if
// input sample channel: valid, ready, sample and last marker
// ----------------------------------------------------------------------------
interface firfc_smp_if #(
    parameter int SAMPLE_WIDTH = firfc_pkg::SAMPLE_W_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_in;

    modport source (output valid, output sample, output last_in, input ready);
    modport sink   (input valid, input sample, input last_in, output ready);
endinterface

[sv/firfc_res_if.sv]
// ----------------------------------------------------------------------------
// firfc_res_if
// result channel: valid, ready, accumulated value and last marker
// ----------------------------------------------------------------------------
interface firfc_res_if ();
    logic                                 valid;
    logic                                 ready;
    logic signed [firfc_pkg::VALUE_W-1:0] value;
    logic                                 last_out;

    modport source (output valid, output value, output last_out, input ready);
    modport sink   (input valid, input value, input last_out, output ready);
endinterface

[sv/firfc_front.sv]
// ----------------------------------------------------------------------------
// firfc_front
// accepts sample items and queues them with their last marker
// ----------------------------------------------------------------------------
module firfc_front #(
    parameter int SAMPLE_WIDTH = firfc_pkg::SAMPLE_W_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    firfc_smp_if.sink               i_smp,
    input  logic                    i_pop,
    output logic                    o_q_valid,
    output logic [SAMPLE_WIDTH-1:0] o_q_sample,
    output logic                    o_q_last
);
    localparam int PTR_W = $clog2(firfc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(firfc_pkg::QUEUE_DEPTH + 1);

    logic [SAMPLE_WIDTH-1:0] r_smp [firfc_pkg::QUEUE_DEPTH];
    logic                    r_lst [firfc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]        r_wr, r_rd;
    logic [CNT_W-1:0]        r_cnt;
    logic                    w_push, w_pop;

    assign i_smp.ready = (r_cnt != CNT_W'(firfc_pkg::QUEUE_DEPTH));
    assign w_push      = i_smp.valid && i_smp.ready;
    assign w_pop       = i_pop && (r_cnt != '0);

    assign o_q_valid   = (r_cnt != '0);
    assign o_q_sample  = r_smp[r_rd];
    assign o_q_last    = r_lst[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(firfc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(firfc_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_smp[r_wr] <= i_smp.sample;
            r_lst[r_wr] <= i_smp.last_in;
        end
    end
endmodule

[sv/firfc_seq.sv]
// ----------------------------------------------------------------------------
// firfc_seq
// delay line and tail sequencer, issues one sample window per step
// ----------------------------------------------------------------------------
module firfc_seq #(
    parameter int TAPS         = firfc_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = firfc_pkg::SAMPLE_W_DEF,
    parameter int NW           = $clog2(TAPS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic [NW-1:0]                     i_n,
    input  logic                              i_q_valid,
    input  logic [SAMPLE_WIDTH-1:0]           i_q_sample,
    input  logic                              i_q_last,
    output logic                              o_pop,
    output logic [TAPS-1:0][SAMPLE_WIDTH-1:0] o_win,
    output firfc_pkg::t_ctl                   o_ctl
);
    localparam int DEPTH = TAPS - 1;

    logic [DEPTH-1:0][SAMPLE_WIDTH-1:0] r_dly, n_dly;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0]  r_win, n_win;
    logic [NW-1:0]                      r_tail, n_tail;
    firfc_pkg::t_ctl                    r_ctl, n_ctl;
    logic                               w_tail, w_issue, w_clear;

    assign w_tail  = (r_tail != '0);
    assign w_issue = w_tail || i_q_valid;
    assign o_pop   = i_adv && !w_tail;
    // the final output of a signal also empties the delay line
    assign w_clear = w_tail ? (r_tail == NW'(1)) : (i_q_last && (i_n == NW'(1)));

    always_comb begin
        n_win[0] = w_tail ? '0 : i_q_sample;
        for (int j = 1; j < TAPS; j++) begin
            n_win[j] = r_dly[j-1];
        end

        n_dly = r_dly;
        if (i_adv && w_issue) begin
            if (w_clear) begin
                n_dly = '0;
            end else begin
                for (int j = DEPTH - 1; j > 0; j--) begin
                    n_dly[j] = r_dly[j-1];
                end
                n_dly[0] = n_win[0];
            end
        end

        n_tail = r_tail;
        if (i_adv) begin
            if (w_tail) begin
                n_tail = r_tail - NW'(1);
            end else if (i_q_valid && i_q_last && (i_n != NW'(1))) begin
                n_tail = i_n - NW'(1);
            end
        end

        n_ctl.valid = w_issue;
        n_ctl.last  = w_clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly  <= '0;
            r_tail <= '0;
            r_ctl  <= '0;
        end else begin
            r_dly  <= n_dly;
            r_tail <= n_tail;
            if (i_adv) begin
                r_ctl <= n_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;
    assign o_ctl = r_ctl;
endmodule

[sv/firfc_mac.sv]
// ----------------------------------------------------------------------------
// firfc_mac
// coefficient selection, tap products, registered adder tree and output register
// ----------------------------------------------------------------------------
module firfc_mac #(
    parameter int TAPS         = firfc_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = firfc_pkg::SAMPLE_W_DEF,
    parameter int NW           = $clog2(TAPS + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [NW-1:0]                     i_n,
    input  logic                              i_reverse,
    input  logic [firfc_pkg::CFG_W-1:0]       i_coef_lo,
    input  logic [firfc_pkg::CFG_W-1:0]       i_coef_hi,
    input  logic [TAPS-1:0][SAMPLE_WIDTH-1:0] i_win,
    input  firfc_pkg::t_ctl                   i_ctl,
    output logic                              o_adv,
    firfc_res_if.source                       o_res
);
    localparam int VW    = firfc_pkg::VALUE_W;
    localparam int PW    = SAMPLE_WIDTH + firfc_pkg::COEF_W;
    localparam int EXT_W = (PW > VW) ? PW : VW;
    localparam int NGRP  = (TAPS + firfc_pkg::GROUP - 1) / firfc_pkg::GROUP;

    logic signed [firfc_pkg::COEF_W-1:0] r_coef [TAPS];
    logic signed [firfc_pkg::COEF_W-1:0] n_coef [TAPS];
    logic signed [PW-1:0]                w_prod [TAPS];
    logic signed [EXT_W-1:0]             w_pext [TAPS];
    logic [VW-1:0]                       r_p [TAPS];
    logic [VW-1:0]                       r_g [NGRP];
    logic [VW-1:0]                       n_g [NGRP];
    logic [VW-1:0]                       n_sum;
    logic [VW-1:0]                       r_val;
    firfc_pkg::t_ctl                     r_c1, r_c2;
    logic                                r_ov, r_ol;

    // taps in use, optionally read backward for correlation
    always_comb begin
        for (int j = 0; j < TAPS; j++) begin
            if (j < int'(i_n)) begin
                n_coef[j] = firfc_pkg::tap_of(i_coef_lo, i_coef_hi,
                                              i_reverse ? (int'(i_n) - 1 - j) : j);
            end else begin
                n_coef[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_adv = !r_ov || o_res.ready;

    always_comb begin
        for (int j = 0; j < TAPS; j++) begin
            w_prod[j] = $signed(i_win[j]) * r_coef[j];
            w_pext[j] = EXT_W'(w_prod[j]);
        end
        for (int g = 0; g < NGRP; g++) begin
            n_g[g] = '0;
            for (int i = 0; i < firfc_pkg::GROUP; i++) begin
                if (g * firfc_pkg::GROUP + i < TAPS) begin
                    n_g[g] = n_g[g] + r_p[g * firfc_pkg::GROUP + i];
                end
            end
        end
        n_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_sum = n_sum + r_g[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_ov <= 1'b0;
        end else if (o_adv) begin
            r_c1 <= i_ctl;
            r_c2 <= r_c1;
            r_ov <= r_c2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            for (int j = 0; j < TAPS; j++) begin
                r_p[j] <= w_pext[j][VW-1:0];
            end
            r_g   <= n_g;
            r_val <= n_sum;
            r_ol  <= r_c2.last;
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.value    = $signed(r_val);
    assign o_res.last_out = r_ol;
endmodule

[sv/fir_full_convolution.sv]
// ----------------------------------------------------------------------------
// fir_full_convolution
// streaming direct-form fir filter giving the full linear convolution
// ----------------------------------------------------------------------------
// path: queue, then window, product, group and output registers, then o_res
// throughput: one sample item per cycle unless o_res stalls; a last item holds
//   the back end for its own output plus n-1 tail outputs, n = active tap count
// the rate is set by the single window issue per cycle in the sequencer
// reset: synchronous active low; clears queue, delay line, tail counter,
//   pipeline valids and loads tap_count 1, coefficients 0, forward order
module fir_full_convolution #(
    parameter int TAPS         = firfc_pkg::TAPS_DEF,
    parameter int SAMPLE_WIDTH = firfc_pkg::SAMPLE_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    firfc_smp_if.sink                       i_smp,
    firfc_res_if.source                     o_res,
    input  logic                            i_cfg_we,
    input  logic [firfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [firfc_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int NW = $clog2(TAPS + 1);

    // configuration registers
    logic [firfc_pkg::TAP_COUNT_W-1:0] r_tap_count;
    logic [firfc_pkg::CFG_W-1:0]       r_coef_lo;
    logic [firfc_pkg::CFG_W-1:0]       r_coef_hi;
    logic                              r_reverse;

    // front to back queue
    logic                    w_pop;
    logic                    w_q_valid;
    logic [SAMPLE_WIDTH-1:0] w_q_sample;
    logic                    w_q_last;

    // sequencer to mac
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0] w_win;
    firfc_pkg::t_ctl                   w_ctl;
    logic                              w_adv;
    logic [NW-1:0]                     w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= firfc_pkg::TAP_COUNT_W'(1);
            r_coef_lo   <= '0;
            r_coef_hi   <= '0;
            r_reverse   <= 1'b0;
        end else if (i_cfg_we) begin
            case (firfc_pkg::t_cfg_idx'(i_cfg_idx))
                firfc_pkg::CFG_TAP_COUNT: begin
                    r_tap_count <= i_cfg_data[firfc_pkg::TAP_COUNT_W-1:0];
                end
                firfc_pkg::CFG_COEF_LOW: begin
                    r_coef_lo <= i_cfg_data;
                end
                firfc_pkg::CFG_COEF_HIGH: begin
                    r_coef_hi <= i_cfg_data;
                end
                firfc_pkg::CFG_REVERSE: begin
                    r_reverse <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // active tap count: zero acts as one, above the tap array acts as all taps
    always_comb begin
        if (r_tap_count == '0) begin
            w_n = NW'(1);
        end else if (int'(r_tap_count) > TAPS) begin
            w_n = NW'(TAPS);
        end else begin
            w_n = NW'(r_tap_count);
        end
    end

    // front: takes sample items into a short queue
    firfc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (i_smp),
        .i_pop      (w_pop),
        .o_q_valid  (w_q_valid),
        .o_q_sample (w_q_sample),
        .o_q_last   (w_q_last)
    );

    // back: sequencer walks samples and tail flushes through the delay line
    firfc_seq #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .NW           (NW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_n        (w_n),
        .i_q_valid  (w_q_valid),
        .i_q_sample (w_q_sample),
        .i_q_last   (w_q_last),
        .o_pop      (w_pop),
        .o_win      (w_win),
        .o_ctl      (w_ctl)
    );

    // back: products, adder tree and output register, stalled from o_res
    firfc_mac #(
        .TAPS         (TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .NW           (NW)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_n       (w_n),
        .i_reverse (r_reverse),
        .i_coef_lo (r_coef_lo),
        .i_coef_hi (r_coef_hi),
        .i_win     (w_win),
        .i_ctl     (w_ctl),
        .o_adv     (w_adv),
        .o_res     (o_res)
    );
endmodule
